FILE: design/dynamic_op_table_block_scrambler_assert.svh
// assertion macros for the block scrambler
`ifndef DYNAMIC_OP_TABLE_BLOCK_SCRAMBLER_ASSERT_SVH
`define DYNAMIC_OP_TABLE_BLOCK_SCRAMBLER_ASSERT_SVH
`ifndef SYNTHESIS
`define DOTS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DOTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DOTS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define DOTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/dots_pkg.sv
// shared types and operation constants for the block scrambler
package dots_pkg;

  typedef enum logic [1:0] {
    OPK_PERM,
    OPK_XOR,
    OPK_NOT
  } op_kind_t;

  typedef struct packed {
    logic init;
    logic swap;
    logic chk;
  } tbl_ctl_t;

  localparam int unsigned NUM_OPS = 16;
  localparam int unsigned NUM_BYTES = 8;

  localparam op_kind_t OP_KIND [NUM_OPS] = '{
    OPK_PERM, OPK_XOR, OPK_XOR, OPK_PERM, OPK_PERM, OPK_XOR, OPK_XOR, OPK_PERM,
    OPK_PERM, OPK_XOR, OPK_PERM, OPK_PERM, OPK_XOR, OPK_NOT, OPK_XOR, OPK_XOR
  };

  localparam logic [7:0] OP_BYTES [NUM_OPS][NUM_BYTES] = '{
    '{8'h10, 8'h01, 8'h08, 8'h80, 8'h40, 8'h20, 8'h02, 8'h04},
    '{8'd219, 8'd137, 8'd7, 8'd224, 8'd99, 8'd62, 8'd187, 8'd231},
    '{8'd232, 8'd190, 8'd186, 8'd126, 8'd241, 8'd177, 8'd59, 8'd254},
    '{8'h40, 8'h80, 8'h20, 8'h08, 8'h04, 8'h01, 8'h02, 8'h10},
    '{8'h20, 8'h80, 8'h40, 8'h10, 8'h04, 8'h01, 8'h02, 8'h08},
    '{8'd223, 8'd19, 8'd86, 8'd176, 8'd218, 8'd45, 8'd62, 8'd205},
    '{8'd120, 8'd165, 8'd243, 8'd143, 8'd252, 8'd222, 8'd86, 8'd201},
    '{8'h80, 8'h10, 8'h01, 8'h20, 8'h10, 8'h02, 8'h04, 8'h08},
    '{8'h10, 8'h40, 8'h02, 8'h04, 8'h08, 8'h80, 8'h20, 8'h01},
    '{8'd221, 8'd231, 8'd188, 8'd167, 8'd243, 8'd66, 8'd210, 8'd197},
    '{8'h01, 8'h02, 8'h04, 8'h10, 8'h08, 8'h20, 8'h40, 8'h80},
    '{8'h04, 8'h20, 8'h80, 8'h01, 8'h10, 8'h08, 8'h02, 8'h40},
    '{8'd236, 8'd240, 8'd197, 8'd246, 8'd160, 8'd224, 8'd253, 8'd237},
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd234, 8'd105, 8'd102, 8'd91, 8'd122, 8'd211, 8'd176, 8'd215},
    '{8'd180, 8'd187, 8'd192, 8'd169, 8'd244, 8'd52, 8'd227, 8'd161}
  };

endpackage

FILE: design/dots_op_unit.sv
// shared operation unit: xor, transpose, or complement of the lower four bytes of one block
module dots_op_unit (
  input  logic [3:0]  op,
  input  logic [63:0] blk_in,
  output logic [63:0] blk_out
);
  import dots_pkg::*;

  logic [7:0] b    [NUM_BYTES];
  logic [7:0] t    [NUM_BYTES];
  logic [7:0] mask [NUM_BYTES];

  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      b[i]    = blk_in[8*i +: 8];
      mask[i] = OP_BYTES[op][i];
      t[i]    = b[i];
    end
    case (OP_KIND[op])
      OPK_XOR: begin
        for (int i = 0; i < NUM_BYTES; i++) t[i] = b[i] ^ mask[i];
      end
      OPK_NOT: begin
        for (int i = 0; i < 4; i++) t[i] = ~b[i];
      end
      OPK_PERM: begin
        for (int i = 0; i < NUM_BYTES; i++) begin
          t[i] = 8'h00;
          for (int j = 0; j < NUM_BYTES; j++) t[i] = t[i] | ({8{b[j][i]}} & mask[j]);
        end
      end
      default: begin
        for (int i = 0; i < NUM_BYTES; i++) t[i] = b[i];
      end
    endcase
    for (int i = 0; i < NUM_BYTES; i++) blk_out[8*i +: 8] = t[i];
  end

endmodule

FILE: design/dots_op_table.sv
// operation table: lookup, slot swap, rotate and identity reset
module dots_op_table (
  input  logic              clk,
  input  logic              rst_n,
  input  dots_pkg::tbl_ctl_t ctl,
  input  logic [3:0]        sel_addr,
  input  logic [7:0]        upd_byte,
  input  logic [3:0]        first_op,
  output logic [3:0]        sel_op,
  output logic [3:0]        slot_lo
);
  import dots_pkg::*;

  logic [3:0] tbl_r   [NUM_OPS];
  logic [3:0] swp     [NUM_OPS];
  logic [3:0] tbl_nxt [NUM_OPS];
  logic [3:0] lo;
  logic [3:0] hi;

  assign lo      = upd_byte[3:0];
  assign hi      = upd_byte[7:4];
  assign sel_op  = tbl_r[sel_addr];
  assign slot_lo = tbl_r[lo];

  always_comb begin
    for (int k = 0; k < NUM_OPS; k++) swp[k] = tbl_r[k];
    swp[lo] = tbl_r[hi];
    swp[hi] = tbl_r[lo];
    for (int k = 0; k < NUM_OPS; k++) begin
      if (ctl.chk && (slot_lo == first_op)) begin
        tbl_nxt[k] = swp[4'(k + 1)];
      end else begin
        tbl_nxt[k] = swp[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int k = 0; k < NUM_OPS; k++) tbl_r[k] <= 4'(k);
    end else if (ctl.swap) begin
      for (int k = 0; k < NUM_OPS; k++) tbl_r[k] <= tbl_nxt[k];
    end
  end

endmodule

FILE: design/dynamic_op_table_block_scrambler.sv
// top level of the dynamic operation table block scrambler
//
// in channel: in_valid/in_ready with in_kind, in_block_in, in_last_block.
// in_kind 0 resets the operation table to identity in the accepting cycle
// and gives no result; in_kind 1 scrambles one 8-byte block.
// out channel: out_valid/out_ready with out_block_out and out_last_out.
// a block runs two table steps per byte, each running one operation
// through the shared operation unit and swapping two slots; the second
// step also rotates the table if both moved the same op from slot lo.
// the last step loads the output register and raises out_valid.
// in_ready is high whenever no block is in progress, also while a
// result waits in the output register; a new block is accepted only
// once the previous one has finished all of its steps.
// if the receiver stalls, the final step of the next block holds until
// the output register is free; nothing is lost.
// reset (rst_n low, synchronous) clears the handshake state and restores
// the identity table.
module dynamic_op_table_block_scrambler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_block_in,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_block_out,
  output logic        out_last_out
);
  import dots_pkg::*;

  `include "dynamic_op_table_block_scrambler_assert.svh"

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] blk_r, blk_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        phase_r, phase_nxt;
  logic [3:0]  first_r, first_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_block_r, out_block_nxt;
  logic        out_last_r, out_last_nxt;

  logic [7:0]  cur_byte;
  logic [7:0]  new_byte;
  logic [3:0]  sel_addr;
  logic [3:0]  sel_op;
  logic [3:0]  slot_lo;
  logic [63:0] op_block;
  logic        step_en;
  logic        in_acc;
  tbl_ctl_t    ctl;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cur_byte = blk_r[{idx_r, 3'b000} +: 8];
  assign new_byte = op_block[{idx_r, 3'b000} +: 8];
  assign sel_addr = phase_r ? cur_byte[7:4] : cur_byte[3:0];
  assign step_en  = (state_r == ST_RUN) &&
                    !(phase_r && (idx_r == 3'd7) && out_valid_r && !out_ready);

  assign ctl.init = in_acc && !in_kind;
  assign ctl.swap = step_en;
  assign ctl.chk  = step_en && phase_r;

  dots_op_unit u_op (
    .op      (sel_op),
    .blk_in  (blk_r),
    .blk_out (op_block)
  );

  dots_op_table u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sel_addr (sel_addr),
    .upd_byte (new_byte),
    .first_op (first_r),
    .sel_op   (sel_op),
    .slot_lo  (slot_lo)
  );

  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    phase_nxt     = phase_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_block_nxt = out_block_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_kind) begin
          blk_nxt   = in_block_in;
          last_nxt  = in_last_block;
          idx_nxt   = 3'd0;
          phase_nxt = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_en) begin
          blk_nxt = op_block;
          if (!phase_r) begin
            first_nxt = slot_lo;
            phase_nxt = 1'b1;
          end else begin
            phase_nxt = 1'b0;
            idx_nxt   = idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              state_nxt     = ST_IDLE;
              out_valid_nxt = 1'b1;
              out_block_nxt = op_block;
              out_last_nxt  = last_r;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 3'd0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blk_r       <= blk_nxt;
    last_r      <= last_nxt;
    first_r     <= first_nxt;
    out_block_r <= out_block_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_block_out = out_block_r;
  assign out_last_out  = out_last_r;

  `DOTS_ASSERT_SAME(a_idle_at_start, clk, rst_n, state_r == ST_IDLE, (idx_r == 3'd0) && !phase_r)
  `DOTS_ASSERT_NEXT(a_scramble_starts, clk, rst_n, in_acc && in_kind, state_r == ST_RUN)
  `DOTS_ASSERT_SAME(a_result_from_run, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_RUN))
  `DOTS_ASSERT_NEXT(a_init_no_result, clk, rst_n, in_acc && !in_kind && !out_valid_r, !out_valid_r)

endmodule

FILE: verif/tb.sv
// testbench for the block scrambler: random requests checked against a table predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dots_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam op_kind_t SLOT_KIND [16] = '{
    OPK_PERM, OPK_XOR, OPK_XOR, OPK_PERM, OPK_PERM, OPK_XOR, OPK_XOR, OPK_PERM,
    OPK_PERM, OPK_XOR, OPK_PERM, OPK_PERM, OPK_XOR, OPK_NOT, OPK_XOR, OPK_XOR
  };

  localparam bit [7:0] SLOT_BYTES [16][8] = '{
    '{8'h10, 8'h01, 8'h08, 8'h80, 8'h40, 8'h20, 8'h02, 8'h04},
    '{8'd219, 8'd137, 8'd7, 8'd224, 8'd99, 8'd62, 8'd187, 8'd231},
    '{8'd232, 8'd190, 8'd186, 8'd126, 8'd241, 8'd177, 8'd59, 8'd254},
    '{8'h40, 8'h80, 8'h20, 8'h08, 8'h04, 8'h01, 8'h02, 8'h10},
    '{8'h20, 8'h80, 8'h40, 8'h10, 8'h04, 8'h01, 8'h02, 8'h08},
    '{8'd223, 8'd19, 8'd86, 8'd176, 8'd218, 8'd45, 8'd62, 8'd205},
    '{8'd120, 8'd165, 8'd243, 8'd143, 8'd252, 8'd222, 8'd86, 8'd201},
    '{8'h80, 8'h10, 8'h01, 8'h20, 8'h10, 8'h02, 8'h04, 8'h08},
    '{8'h10, 8'h40, 8'h02, 8'h04, 8'h08, 8'h80, 8'h20, 8'h01},
    '{8'd221, 8'd231, 8'd188, 8'd167, 8'd243, 8'd66, 8'd210, 8'd197},
    '{8'h01, 8'h02, 8'h04, 8'h10, 8'h08, 8'h20, 8'h40, 8'h80},
    '{8'h04, 8'h20, 8'h80, 8'h01, 8'h10, 8'h08, 8'h02, 8'h40},
    '{8'd236, 8'd240, 8'd197, 8'd246, 8'd160, 8'd224, 8'd253, 8'd237},
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd234, 8'd105, 8'd102, 8'd91, 8'd122, 8'd211, 8'd176, 8'd215},
    '{8'd180, 8'd187, 8'd192, 8'd169, 8'd244, 8'd52, 8'd227, 8'd161}
  };

  typedef struct packed {
    bit [63:0] blk;
    bit        last;
  } scrambled_t;

  class block_tracker;
    bit [3:0]    slot_op [16];
    scrambled_t  awaited [$];
    int unsigned failures;

    function new();
      failures = 0;
      restore_identity();
    endfunction

    function void restore_identity();
      for (int i = 0; i < 16; i++) slot_op[i] = 4'(i);
    endfunction

    function bit [63:0] run_slot_op(bit [3:0] op, bit [63:0] v);
      bit [63:0] t;
      t = '0;
      case (SLOT_KIND[op])
        OPK_XOR: begin
          for (int i = 0; i < 8; i++) t[8*i +: 8] = v[8*i +: 8] ^ SLOT_BYTES[op][i];
        end
        OPK_NOT: begin
          t = v;
          t[31:0] = ~v[31:0];
        end
        default: begin
          for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
              if (v[8*j + i]) t[8*i +: 8] |= SLOT_BYTES[op][j];
        end
      endcase
      return t;
    endfunction

    function bit [3:0] swap_slots(bit [7:0] key);
      bit [3:0] first;
      first = slot_op[key[3:0]];
      slot_op[key[3:0]] = slot_op[key[7:4]];
      slot_op[key[7:4]] = first;
      return first;
    endfunction

    function bit [63:0] scramble_block(bit [63:0] v);
      bit [3:0] first;
      bit [3:0] second;
      bit [3:0] keep;
      for (int j = 0; j < 8; j++) begin
        v = run_slot_op(slot_op[v[8*j +: 4]], v);
        first = swap_slots(v[8*j +: 8]);
        v = run_slot_op(slot_op[v[8*j+4 +: 4]], v);
        second = swap_slots(v[8*j +: 8]);
        if (second == first) begin
          keep = slot_op[0];
          for (int k = 0; k < 15; k++) slot_op[k] = slot_op[k+1];
          slot_op[15] = keep;
        end
      end
      return v;
    endfunction

    function void note_request(bit kind, bit [63:0] blk, bit last);
      scrambled_t e;
      if (!kind) begin
        restore_identity();
      end else begin
        e.blk = scramble_block(blk);
        e.last = last;
        awaited.push_back(e);
      end
    endfunction

    function void check_block(bit [63:0] blk, bit last);
      scrambled_t e;
      if (awaited.size() == 0) begin
        $error("out_block_out %h arrived with no request pending", blk);
        failures++;
      end else begin
        e = awaited.pop_front();
        if (blk !== e.blk) begin
          $error("out_block_out expected %h actual %h", e.blk, blk);
          failures++;
        end
        if (last !== e.last) begin
          $error("out_last_out expected %0d actual %0d", e.last, last);
          failures++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [63:0] in_block_in = '0;
  logic        in_last_block = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_block_out;
  logic        out_last_out;

  block_tracker board = new();
  int          burst_left = 0;
  int unsigned cycles = 0;

  dynamic_op_table_block_scrambler DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_block_in   (in_block_in),
    .in_last_block (in_last_block),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_block_out (out_block_out),
    .out_last_out  (out_last_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_request(input bit kind, input bit [63:0] blk, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_block_in <= blk;
    in_last_block <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(kind, blk, last);
  endtask

  function automatic bit [63:0] random_block();
    bit [63:0] v;
    bit [3:0]  n;
    v = {$urandom, $urandom};
    for (int j = 0; j < 8; j++) begin
      if ($urandom_range(0, 7) == 0) begin
        n = 4'($urandom_range(0, 15));
        v[8*j +: 8] = {n, n};
      end
    end
    return v;
  endfunction

  // receiver with changing stall pattern
  initial begin
    int mode;
    int mode_left;
    int stall_left;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_block(out_block_out, out_last_out);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (mode == 1) begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end else if (mode == 2 && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 30);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    bit [63:0] blk;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: table init with junk payload, extremes, equal nibbles
    send_request(1'b0, '1, 1'b1);
    send_request(1'b1, '0, 1'b0);
    send_request(1'b1, '1, 1'b1);
    send_request(1'b1, {8{8'h11}}, 1'b0);
    send_request(1'b1, {8{8'hEE}}, 1'b1);
    send_request(1'b1, 64'h08090A0B0C0D0E0F, 1'b0);
    // every even slot runs first from a fresh table
    for (int k = 0; k < 8; k++) begin
      blk = {$urandom, $urandom};
      blk[7:0] = {4'(2*k + 1), 4'(2*k)};
      send_request(1'b0, {$urandom, $urandom}, 1'($urandom));
      send_request(1'b1, blk, 1'(k));
    end
    send_request(1'b0, '0, 1'b0);

    for (int n = 0; n < 1000; n++) begin
      if ($urandom_range(0, 11) == 0) send_request(1'b0, {$urandom, $urandom}, 1'($urandom));
      else if ($urandom_range(0, 49) == 0) send_request(1'b1, '1, 1'($urandom));
      else send_request(1'b1, random_block(), 1'($urandom));
    end
    in_valid <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.failures == 0 && board.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
